@@ sv/sscs_pkg.sv @@
// Shared types, codes and helpers of the shadow call stack sampler.
`timescale 1ns / 1ps

package sscs_pkg;

  localparam logic [1:0]  ACT_RETIRE = 2'd0;
  localparam logic [1:0]  ACT_START  = 2'd1;
  localparam logic [1:0]  ACT_STOP   = 2'd2;

  localparam logic [3:0]  STAT_RETIRED   = 4'd0;
  localparam logic [3:0]  STAT_SAMPLES   = 4'd1;
  localparam logic [3:0]  STAT_CALLS     = 4'd2;
  localparam logic [3:0]  STAT_RETURNS   = 4'd3;
  localparam logic [3:0]  STAT_UNDERFLOW = 4'd4;
  localparam logic [3:0]  STAT_RESETS    = 4'd5;
  localparam logic [3:0]  STAT_MAXDEPTH  = 4'd6;
  localparam logic [3:0]  STAT_PENDING   = 4'd7;
  localparam logic [3:0]  STAT_OVERFLOW  = 4'd8;

  localparam logic [0:0]  KIND_FRAME = 1'b0;
  localparam logic [0:0]  KIND_STAT  = 1'b1;

  localparam logic [31:0] PERIOD_RESET = 32'd1000;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] inst_pc;
    logic        is_microop;
    logic        is_last_microop;
    logic        is_call;
    logic        is_return;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [47:0] sample_retired;
    logic [63:0] sample_pc;
    logic [5:0]  sample_depth;
    logic [5:0]  frame_index;
    logic [63:0] frame_addr;
    logic [3:0]  stat_id;
    logic [47:0] stat_value;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRAME_RD,
    ST_FRAME_OUT,
    ST_LEAF_OUT,
    ST_REPORT
  } state_t;

  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_FRAME,
    SEL_LEAF,
    SEL_STAT
  } out_sel_t;

  typedef struct packed {
    logic     accept;
    logic     idx_clr;
    logic     frame_inc;
    logic     stat_inc;
    logic     rd_en;
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic sample_hit;
    logic stop_hit;
    logic frame_done;
    logic stat_last;
    logic out_free;
  } sts_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [47:0] sat_inc48(input logic [47:0] v);
    sat_inc48 = (v == 48'hFFFF_FFFF_FFFF) ? v : v + 48'd1;
  endfunction

endpackage

@@ sv/sscs_dp.sv @@
// Datapath: frame memory, stack pointer, statistics counters and output register.
`timescale 1ns / 1ps

module sscs_dp #(
  parameter int FRAME_SLOTS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sscs_pkg::in_item_t  in_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data,
  input  sscs_pkg::cmd_t      cmd,
  output sscs_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_stall,
  output sscs_pkg::out_item_t out_data
);
  import sscs_pkg::*;

  localparam int IW = $clog2(FRAME_SLOTS + 1);
  localparam int AW = $clog2(FRAME_SLOTS);
  localparam logic [IW-1:0] DEPTH_C = IW'(FRAME_SLOTS);

  logic [63:0]   frame_mem [FRAME_SLOTS];
  logic [63:0]   rd_data_r;

  logic [31:0]   sample_period_r;
  logic [IW-1:0] stack_count_r;
  logic          call_pending_r;
  logic          running_r;
  logic [47:0]   retired_total_r;
  logic [31:0]   countdown_r;
  logic [31:0]   samples_r;
  logic [31:0]   calls_r;
  logic [31:0]   returns_r;
  logic [31:0]   underflows_r;
  logic [31:0]   resets_r;
  logic [IW-1:0] deepest_r;
  logic [31:0]   overflows_r;

  logic [IW-1:0] frame_idx_r;
  logic [3:0]    stat_idx_r;
  logic [IW-1:0] dump_count_r;
  logic [63:0]   sample_pc_r;

  logic          out_valid_r;
  out_item_t     out_data_r;
  out_item_t     out_nxt;

  logic          qualify;
  logic          push_ok;
  logic          root_push;
  logic          wr_en;
  logic          periodic;
  logic [IW-1:0] cnt1;
  logic [IW-1:0] cnt2;
  logic [IW-1:0] cnt3;
  logic [47:0]   retired_nxt;
  logic [47:0]   stat_val;

  // Work out what one retired item does to the stack.
  always_comb begin
    qualify   = (in_data.action == ACT_RETIRE) && running_r &&
                !(in_data.is_microop && !in_data.is_last_microop);
    push_ok   = call_pending_r && (stack_count_r != DEPTH_C);
    cnt1      = push_ok ? stack_count_r + IW'(1) : stack_count_r;
    root_push = (cnt1 == '0);
    cnt2      = root_push ? cnt1 + IW'(1) : cnt1;
    wr_en     = push_ok || root_push;
    cnt3      = (in_data.is_return && (cnt2 > IW'(1))) ? cnt2 - IW'(1) : cnt2;
    retired_nxt = sat_inc48(retired_total_r);
    periodic    = (countdown_r <= 32'd1);
  end

  always_comb begin
    sts.sample_hit = qualify && ((retired_nxt == 48'd1) || periodic);
    sts.stop_hit   = (in_data.action == ACT_STOP);
    sts.frame_done = (frame_idx_r == dump_count_r);
    sts.stat_last  = (stat_idx_r == STAT_OVERFLOW);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && qualify && wr_en) begin
      frame_mem[stack_count_r[AW-1:0]] <= in_data.inst_pc;
    end
    if (cmd.rd_en) begin
      rd_data_r <= frame_mem[frame_idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r <= PERIOD_RESET;
      stack_count_r   <= '0;
      call_pending_r  <= 1'b0;
      running_r       <= 1'b0;
      retired_total_r <= '0;
      countdown_r     <= '0;
      samples_r       <= '0;
      calls_r         <= '0;
      returns_r       <= '0;
      underflows_r    <= '0;
      resets_r        <= '0;
      deepest_r       <= '0;
      overflows_r     <= '0;
    end else begin
      if (cfg_we) begin
        sample_period_r <= cfg_data;
      end
      if (cmd.accept) begin
        case (in_data.action)
          ACT_START: begin
            stack_count_r   <= '0;
            call_pending_r  <= 1'b0;
            running_r       <= 1'b1;
            retired_total_r <= '0;
            countdown_r     <= sample_period_r;
            samples_r       <= '0;
            calls_r         <= '0;
            returns_r       <= '0;
            underflows_r    <= '0;
            resets_r        <= '0;
            deepest_r       <= '0;
            overflows_r     <= '0;
          end
          ACT_STOP: begin
            running_r <= 1'b0;
          end
          ACT_RETIRE: begin
            if (qualify) begin
              if (call_pending_r && !push_ok) begin
                overflows_r <= sat_inc32(overflows_r);
              end
              if (root_push) begin
                resets_r <= sat_inc32(resets_r);
              end
              if (cnt2 > deepest_r) begin
                deepest_r <= cnt2;
              end
              retired_total_r <= retired_nxt;
              countdown_r     <= periodic ? sample_period_r : countdown_r - 32'd1;
              if (sts.sample_hit) begin
                samples_r <= sat_inc32(samples_r);
              end
              if (in_data.is_return) begin
                returns_r <= sat_inc32(returns_r);
                if (cnt2 <= IW'(1)) begin
                  underflows_r <= sat_inc32(underflows_r);
                end
              end
              if (in_data.is_call) begin
                calls_r <= sat_inc32(calls_r);
              end
              call_pending_r <= in_data.is_call;
              stack_count_r  <= cnt3;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Snapshot of the stack taken for a dump; the pop of this item does not touch it.
  always_ff @(posedge clk) begin
    if (cmd.accept && sts.sample_hit) begin
      dump_count_r <= cnt2;
      sample_pc_r  <= in_data.inst_pc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_idx_r <= '0;
      stat_idx_r  <= '0;
    end else begin
      if (cmd.idx_clr) begin
        frame_idx_r <= '0;
        stat_idx_r  <= '0;
      end else begin
        if (cmd.frame_inc) begin
          frame_idx_r <= frame_idx_r + IW'(1);
        end
        if (cmd.stat_inc) begin
          stat_idx_r <= stat_idx_r + 4'd1;
        end
      end
    end
  end

  always_comb begin
    case (stat_idx_r)
      STAT_RETIRED:   stat_val = retired_total_r;
      STAT_SAMPLES:   stat_val = 48'(samples_r);
      STAT_CALLS:     stat_val = 48'(calls_r);
      STAT_RETURNS:   stat_val = 48'(returns_r);
      STAT_UNDERFLOW: stat_val = 48'(underflows_r);
      STAT_RESETS:    stat_val = 48'(resets_r);
      STAT_MAXDEPTH:  stat_val = 48'(deepest_r);
      STAT_PENDING:   stat_val = 48'(call_pending_r);
      STAT_OVERFLOW:  stat_val = 48'(overflows_r);
      default:        stat_val = '0;
    endcase
  end

  always_comb begin
    out_nxt = '0;
    case (cmd.out_sel)
      SEL_FRAME: begin
        out_nxt.kind           = KIND_FRAME;
        out_nxt.sample_retired = retired_total_r;
        out_nxt.sample_pc      = sample_pc_r;
        out_nxt.sample_depth   = 6'(dump_count_r) + 6'd1;
        out_nxt.frame_index    = 6'(frame_idx_r);
        out_nxt.frame_addr     = rd_data_r;
      end
      SEL_LEAF: begin
        out_nxt.kind           = KIND_FRAME;
        out_nxt.sample_retired = retired_total_r;
        out_nxt.sample_pc      = sample_pc_r;
        out_nxt.sample_depth   = 6'(dump_count_r) + 6'd1;
        out_nxt.frame_index    = 6'(dump_count_r);
        out_nxt.frame_addr     = sample_pc_r;
        out_nxt.last           = 1'b1;
      end
      SEL_STAT: begin
        out_nxt.kind       = KIND_STAT;
        out_nxt.stat_id    = stat_idx_r;
        out_nxt.stat_value = stat_val;
        out_nxt.last       = (stat_idx_r == STAT_OVERFLOW);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_sel != SEL_NONE) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_sel != SEL_NONE) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/sscs_ctrl.sv @@
// Controller: accepts items and sequences sample dumps and stop reports.
`timescale 1ns / 1ps

module sscs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sscs_pkg::sts_t sts,
  output sscs_pkg::cmd_t cmd
);
  import sscs_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.stop_hit) begin
            state_nxt = ST_REPORT;
          end else if (sts.sample_hit) begin
            state_nxt = ST_FRAME_RD;
          end
        end
      end
      ST_FRAME_RD: begin
        state_nxt = sts.frame_done ? ST_LEAF_OUT : ST_FRAME_OUT;
      end
      ST_FRAME_OUT: begin
        if (sts.out_free) begin
          state_nxt = ST_FRAME_RD;
        end
      end
      ST_LEAF_OUT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (sts.out_free && sts.stat_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.accept  = in_valid;
        cmd.idx_clr = in_valid;
      end
      ST_FRAME_RD: begin
        cmd.rd_en = !sts.frame_done;
      end
      ST_FRAME_OUT: begin
        if (sts.out_free) begin
          cmd.out_sel   = SEL_FRAME;
          cmd.frame_inc = 1'b1;
        end
      end
      ST_LEAF_OUT: begin
        if (sts.out_free) begin
          cmd.out_sel = SEL_LEAF;
        end
      end
      ST_REPORT: begin
        if (sts.out_free) begin
          cmd.out_sel  = SEL_STAT;
          cmd.stat_inc = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/shadow_call_stack_sampler.sv @@
// Top level of the shadow call stack sampler.
//
// Input channel (in_valid / in_stall / in_data) carries retired-instruction
// events and start / stop actions. Output channel (out_valid / out_stall /
// out_data) carries sample frames and stop-report statistics. The user must
// write the sample period register (cfg_valid / cfg_ready / cfg_data) only
// while the block is idle, which it does not enforce; cfg_ready is always high.
//
// An item that produces no result is taken without a stall, and the next item
// can be taken in the following cycle. An item that triggers a sample of n
// stored frames holds in_stall while each frame is read through the frame
// memory read port and then loaded into the output register; the leaf follows.
// A stop item holds in_stall while the nine statistics leave. The first
// statistic of a stop enters the output register from the report state; the
// first frame of a sample from the frame-out state, behind the memory read.
//
// Reset (rst_n low, synchronous) stops the block, clears the stack and all
// counters and sets the period to 1000. While the receiver stalls, the output
// register holds its item and the sequencer waits; no result is dropped.
`timescale 1ns / 1ps

module shadow_call_stack_sampler #(
  parameter int FRAME_SLOTS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sscs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sscs_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);
  import sscs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  sscs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sscs_dp #(
    .FRAME_SLOTS (FRAME_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
